// File: src/rgb_kernel_convolution_filter_defines.svh
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_filter_defines
// Assertion macros shared by the filter modules.
// ----------------------------------------------------------------------------
`ifndef RGB_KERNEL_CONVOLUTION_FILTER_DEFINES_SVH
`define RGB_KERNEL_CONVOLUTION_FILTER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RKCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RKCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rkcf_pkg.sv
// ----------------------------------------------------------------------------
// rkcf_pkg
// Types, constants and tap arithmetic for the RGB convolution filter.
// ----------------------------------------------------------------------------
package rkcf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 21;
    localparam int PIX_W      = 24;
    localparam int LINES      = 4;
    localparam int LBUF_W     = LINES * PIX_W;
    localparam int KSIZE      = 5;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_BOX     = 2'd0,
        MODE_GAUSS   = 2'd1,
        MODE_OUTLINE = 2'd2,
        MODE_EMBOSS  = 2'd3
    } mode_t;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;

    typedef struct packed {
        mode_t            mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [1:0]       half;
    } cfg_t;

    typedef struct packed {
        logic             store;
        logic             produce;
        logic             last;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] oc;
        logic [COL_W-1:0] orow;
    } item_t;

    localparam logic signed [6:0] WEIGHTS [4][25] = '{
        '{ 7'sd0, 7'sd0,  7'sd0,  7'sd0,  7'sd0,
           7'sd0, 7'sd0,  7'sd0,  7'sd0,  7'sd0,
           7'sd0, 7'sd0,  7'sd1,  7'sd1,  7'sd1,
           7'sd0, 7'sd0,  7'sd1,  7'sd1,  7'sd1,
           7'sd0, 7'sd0,  7'sd1,  7'sd1,  7'sd1 },
        '{ 7'sd1, 7'sd4,  7'sd7,  7'sd4,  7'sd1,
           7'sd4, 7'sd16, 7'sd26, 7'sd16, 7'sd4,
           7'sd7, 7'sd26, 7'sd41, 7'sd26, 7'sd7,
           7'sd4, 7'sd16, 7'sd26, 7'sd16, 7'sd4,
           7'sd1, 7'sd4,  7'sd7,  7'sd4,  7'sd1 },
        '{ 7'sd0, 7'sd0,  7'sd0,  7'sd0,  7'sd0,
           7'sd0, 7'sd0,  7'sd0,  7'sd0,  7'sd0,
           7'sd0, 7'sd0,  7'sd0, -7'sd1,  7'sd0,
           7'sd0, 7'sd0, -7'sd1,  7'sd5, -7'sd1,
           7'sd0, 7'sd0,  7'sd0, -7'sd1,  7'sd0 },
        '{ 7'sd0, 7'sd0,  7'sd0,  7'sd0,  7'sd0,
           7'sd0, 7'sd0,  7'sd0,  7'sd0,  7'sd0,
           7'sd0, 7'sd0, -7'sd2, -7'sd1,  7'sd0,
           7'sd0, 7'sd0, -7'sd1,  7'sd1,  7'sd1,
           7'sd0, 7'sd0,  7'sd0,  7'sd1,  7'sd2 }
    };

    // floor(p*w/D); /9 and /273 by reciprocal, exact over the product range
    function automatic logic signed [11:0] tap_value(mode_t mode, logic signed [6:0] wt,
                                                      logic [7:0] p);
        logic [5:0]  mag;
        logic [13:0] prod;
        logic [27:0] scaled;
        logic [10:0] q;
        mag  = wt[6] ? 6'(-wt) : 6'(wt);
        prod = 14'(p) * 14'(mag);
        unique case (mode)
            MODE_BOX:     scaled = (28'(prod) * 28'd57) >> 9;
            MODE_GAUSS:   scaled = (28'(prod) * 28'd15364) >> 22;
            MODE_OUTLINE: scaled = 28'(prod);
            MODE_EMBOSS:  scaled = 28'(prod);
            default:      scaled = 28'(prod);
        endcase
        q = scaled[10:0];
        return wt[6] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

endpackage

// File: src/rgb_kernel_convolution_filter.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_filter
// RGB raster convolution: box 3x3, Gaussian 5x5, outline 3x3, emboss 3x3.
// ----------------------------------------------------------------------------
// Result path: a result passes the s1, s2, s3 and output registers after the beat that
//   completes its window (that beat is h*W+h beats after the center pixel, h = 1 or 2).
// Throughput: one beat per cycle unless stalled; one line-memory column read, write each.
// Reset: box mode, 1024x1024, position zero; line memory is not cleared,
//   taps outside the frame are masked.
module rgb_kernel_convolution_filter
    import rkcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // red_out, green_out, blue_out, out_column, out_row
    output logic        m_axis_tlast,   // last_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    mode_t            mode_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    cfg_t             cfg;
    logic             en, acc;
    item_t            item, s2_item;
    logic             s2_valid, out_valid, out_last;
    window_t          win;
    logic [KSIZE-1:0] row_ok, col_ok;
    logic [23:0]      out_rgb;
    logic [COL_W-1:0] out_col, out_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BOX;
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode   = mode_reg;
        cfg.half   = (mode_reg == MODE_GAUSS) ? 2'd2 : 2'd1;
        cfg.width  = (width_reg == '0) ? DIM_W'(1)
                   : (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        cfg.height = (height_reg == '0) ? DIM_W'(1)
                   : (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    end

    assign cfg_ready     = 1'b1;
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && en;

    rkcf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .acc   (acc),
        .item  (item)
    );

    rkcf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .acc      (acc),
        .pixel    (s_axis_tdata),
        .item     (item),
        .cfg      (cfg),
        .s2_valid (s2_valid),
        .s2_item  (s2_item),
        .win      (win),
        .row_ok   (row_ok),
        .col_ok   (col_ok)
    );

    rkcf_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (cfg.mode),
        .s2_valid  (s2_valid),
        .s2_item   (s2_item),
        .win       (win),
        .row_ok    (row_ok),
        .col_ok    (col_ok),
        .out_valid (out_valid),
        .out_rgb   (out_rgb),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_last  (out_last)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'b0, out_row, out_col, out_rgb};
    assign m_axis_tlast  = out_last;

endmodule

// File: src/rkcf_seq.sv
// ----------------------------------------------------------------------------
// rkcf_seq
// Stream position counters: input position and output window center.
// ----------------------------------------------------------------------------
`include "rgb_kernel_convolution_filter_defines.svh"

module rkcf_seq
    import rkcf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  acc,
    output item_t item
);

    logic [CNT_W-1:0] n_reg, n_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] oc_reg, oc_next;
    logic [COL_W-1:0] orow_reg, orow_next;

    logic [CNT_W-1:0] lat, frame, total, n_cur, m;
    logic [COL_W-1:0] col_cur, oc_cur, orow_cur;
    logic             wrap, produce;

    always_comb
    begin
        lat   = (cfg.half == 2'd2) ? CNT_W'({cfg.width, 1'b0}) + CNT_W'(2)
                                   : CNT_W'(cfg.width) + CNT_W'(1);
        frame = CNT_W'(cfg.width) * CNT_W'(cfg.height);
        total = frame + lat;
        wrap  = n_reg >= total;
        n_cur = wrap ? '0 : n_reg;
        col_cur  = wrap ? '0 : col_reg;
        oc_cur   = (n_cur == '0) ? '0 : oc_reg;
        orow_cur = (n_cur == '0) ? '0 : orow_reg;
        produce  = n_cur >= lat;
        m        = n_cur - lat;

        item.store   = n_cur < frame;
        item.produce = produce;
        item.last    = produce && (m == frame - CNT_W'(1));
        item.col     = col_cur;
        item.oc      = oc_cur;
        item.orow    = orow_cur;

        n_next = n_cur + CNT_W'(1);
        if (n_next >= total)
        begin
            n_next = '0;
        end
        col_next = ((DIM_W'(col_cur) + DIM_W'(1)) == cfg.width || n_next == '0)
                   ? '0 : col_cur + COL_W'(1);
        oc_next   = oc_cur;
        orow_next = orow_cur;
        if (produce)
        begin
            if ((DIM_W'(oc_cur) + DIM_W'(1)) == cfg.width)
            begin
                oc_next   = '0;
                orow_next = orow_cur + COL_W'(1);
            end
            else
            begin
                oc_next = oc_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            col_reg  <= '0;
            oc_reg   <= '0;
            orow_reg <= '0;
        end
        else if (acc)
        begin
            n_reg    <= n_next;
            col_reg  <= col_next;
            oc_reg   <= oc_next;
            orow_reg <= orow_next;
        end
    end

    `RKCF_ASSERT_NEXT(a_last_wraps, acc && item.last, n_reg == '0, "frame end did not wrap")

endmodule

// File: src/rkcf_window.sv
// ----------------------------------------------------------------------------
// rkcf_window
// Line memory (read-modify-write per column) and the 5x5 tap window.
// ----------------------------------------------------------------------------
`include "rgb_kernel_convolution_filter_defines.svh"

module rkcf_window
    import rkcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             acc,
    input  pixel_t           pixel,
    input  item_t            item,
    input  cfg_t             cfg,
    output logic             s2_valid,
    output item_t            s2_item,
    output window_t          win,
    output logic [KSIZE-1:0] row_ok,
    output logic [KSIZE-1:0] col_ok
);

    logic [LBUF_W-1:0] mem [MAX_WIDTH];
    logic [LBUF_W-1:0] rdata_reg;
    logic [LBUF_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    pixel_t            s1_pix_reg;
    logic              s2_valid_reg;
    item_t             s2_item_reg;
    window_t           win_reg;
    logic [KSIZE-1:0]  row_ok_reg, row_ok_next;
    logic [KSIZE-1:0]  col_ok_reg, col_ok_next;

    logic [LBUF_W-1:0] rd_word, wdata;
    pixel_t            new_pix;
    logic signed [12:0] rpos, cpos;

    always_comb
    begin
        rd_word = fwd_reg ? fwd_data_reg : rdata_reg;
        new_pix = s1_item_reg.store ? s1_pix_reg : '0;
        wdata   = {rd_word[LBUF_W-PIX_W-1:0], new_pix};
        for (int i = 0; i < KSIZE; i++)
        begin
            rpos = $signed({3'b0, s1_item_reg.orow}) + 13'(i) - 13'sd4
                   + $signed({11'b0, cfg.half});
            cpos = $signed({3'b0, s1_item_reg.oc}) + 13'(i) - 13'sd4
                   + $signed({11'b0, cfg.half});
            row_ok_next[i] = !rpos[12] && (rpos < $signed({2'b0, cfg.height}));
            col_ok_next[i] = !cpos[12] && (cpos < $signed({2'b0, cfg.width}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && acc)
        begin
            rdata_reg <= mem[item.col];
        end
        if (en && s1_valid_reg)
        begin
            mem[s1_item_reg.col] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && acc)
        begin
            s1_item_reg  <= item;
            s1_pix_reg   <= pixel;
            fwd_data_reg <= wdata;
        end
        if (en && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
            row_ok_reg  <= row_ok_next;
            col_ok_reg  <= col_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            win_reg      <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg && s1_item_reg.produce;
            if (acc)
            begin
                fwd_reg <= s1_valid_reg && (s1_item_reg.col == item.col);
            end
            if (s1_valid_reg)
            begin
                for (int i = 0; i < KSIZE; i++)
                begin
                    for (int j = 0; j < KSIZE - 1; j++)
                    begin
                        win_reg[i][j] <= win_reg[i][j+1];
                    end
                end
                win_reg[4][4] <= new_pix;
                win_reg[3][4] <= rd_word[PIX_W-1:0];
                win_reg[2][4] <= rd_word[2*PIX_W-1:PIX_W];
                win_reg[1][4] <= rd_word[3*PIX_W-1:2*PIX_W];
                win_reg[0][4] <= rd_word[4*PIX_W-1:3*PIX_W];
            end
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_item_reg;
    assign win      = win_reg;
    assign row_ok   = row_ok_reg;
    assign col_ok   = col_ok_reg;

    // back-to-back beats hit the same column only at column zero
    `RKCF_ASSERT_NOW(a_fwd_narrow, s1_valid_reg && fwd_reg, s1_item_reg.col == '0, "bad forward")

endmodule

// File: src/rkcf_arith.sv
// ----------------------------------------------------------------------------
// rkcf_arith
// Tap products, row sums, total, clamp and the output register.
// ----------------------------------------------------------------------------
`include "rgb_kernel_convolution_filter_defines.svh"

module rkcf_arith
    import rkcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  mode_t            mode,
    input  logic             s2_valid,
    input  item_t            s2_item,
    input  window_t          win,
    input  logic [KSIZE-1:0] row_ok,
    input  logic [KSIZE-1:0] col_ok,
    output logic             out_valid,
    output logic [23:0]      out_rgb,
    output logic [COL_W-1:0] out_col,
    output logic [COL_W-1:0] out_row,
    output logic             out_last
);

    logic signed [14:0] rsum_next [3][KSIZE];
    logic signed [14:0] rsum_reg  [3][KSIZE];
    logic               s3_valid_reg;
    item_t              s3_item_reg;
    logic               out_valid_reg;
    logic [23:0]        out_rgb_reg, out_rgb_next;
    item_t              out_item_reg;

    logic [PIX_W-1:0]   p;
    logic signed [17:0] tot;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rsum_next[c][i] = '0;
            end
            for (int j = 0; j < KSIZE; j++)
            begin
                p = (row_ok[i] && col_ok[j]) ? win[i][j] : '0;
                for (int c = 0; c < 3; c++)
                begin
                    rsum_next[c][i] = rsum_next[c][i] + 15'(tap_value(mode,
                        WEIGHTS[mode][i*KSIZE+j], p[c*8 +: 8]));
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tot = '0;
            for (int i = 0; i < KSIZE; i++)
            begin
                tot = tot + 18'(rsum_reg[c][i]);
            end
            if (tot < 0)
            begin
                out_rgb_next[c*8 +: 8] = 8'd0;
            end
            else if (tot > 18'sd255)
            begin
                out_rgb_next[c*8 +: 8] = 8'd255;
            end
            else
            begin
                out_rgb_next[c*8 +: 8] = tot[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid)
        begin
            rsum_reg    <= rsum_next;
            s3_item_reg <= s2_item;
        end
        if (en && s3_valid_reg)
        begin
            out_rgb_reg  <= out_rgb_next;
            out_item_reg <= s3_item_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg  <= s2_valid;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rgb   = out_rgb_reg;
    assign out_col   = out_item_reg.oc;
    assign out_row   = out_item_reg.orow;
    assign out_last  = out_item_reg.last;

    `RKCF_ASSERT_NEXT(a_s3_to_out, s3_valid_reg && en, out_valid_reg, "result dropped")

endmodule
